/* rtl/qai_pkg.sv */
package qai_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CHANNEL_BITS = 8;
   localparam int COORD_W      = FRAC_BITS + 1;
   localparam int ATTR_W       = 3 * CHANNEL_BITS;
   localparam int WGT_W        = 16;
   localparam int PROD_W       = WGT_W + COORD_W;
   localparam int SUM_W        = PROD_W + 2;
   localparam int REM_W        = SUM_W;
   localparam int LERP_W       = CHANNEL_BITS + COORD_W;
   localparam int ACC_W        = LERP_W + 2;
   localparam int ADDR_W       = 5;
   localparam int DATA_W       = 32;
   localparam int DIV_STEPS    = COORD_W;

   localparam logic [COORD_W-1:0] ONE_Q = COORD_W'(1) << FRAC_BITS;

   typedef enum logic [1:0] {
      MODE_DIAG13  = 2'd0,
      MODE_DIAG02  = 2'd1,
      MODE_BILIN   = 2'd2,
      MODE_PERSP   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_MODE     = 3'd0,
      REG_ATTR0    = 3'd1,
      REG_ATTR1    = 3'd2,
      REG_ATTR2    = 3'd3,
      REG_ATTR3    = 3'd4,
      REG_WLOW     = 3'd5,
      REG_WHIGH    = 3'd6,
      REG_NONE     = 3'd7
   } reg_index_type;

   typedef struct packed {
      mode_type           mode;
      logic [ATTR_W-1:0]  attr0;
      logic [ATTR_W-1:0]  attr1;
      logic [ATTR_W-1:0]  attr2;
      logic [ATTR_W-1:0]  attr3;
      logic [31:0]        w_low;
      logic [31:0]        w_high;
   } cfg_type;

   typedef struct packed {
      mode_type           mode;
      logic [1:0]         ia;
      logic [1:0]         ib;
      logic [1:0]         ic;
      logic [COORD_W-1:0] u;
      logic [COORD_W-1:0] v;
      logic [COORD_W-1:0] w3;
      logic [SUM_W-1:0]   s;
      logic [REM_W-1:0]   rem_a;
      logic [REM_W-1:0]   rem_b;
      logic [COORD_W-1:0] quo_a;
      logic [COORD_W-1:0] quo_b;
      logic [ATTR_W-1:0]  p;
      logic [ATTR_W-1:0]  q;
   } item_type;

   function automatic logic [ATTR_W-1:0] corner_attr(input cfg_type cfg, input logic [1:0] k);
      logic [ATTR_W-1:0] r;
      case (k)
         2'd0:    r = cfg.attr0;
         2'd1:    r = cfg.attr1;
         2'd2:    r = cfg.attr2;
         default: r = cfg.attr3;
      endcase
      return r;
   endfunction

   function automatic logic [WGT_W-1:0] corner_weight(input cfg_type cfg, input logic [1:0] k);
      logic [31:0] r;
      r = k[1] ? cfg.w_high : cfg.w_low;
      return k[0] ? r[31:16] : r[15:0];
   endfunction

   function automatic logic [CHANNEL_BITS-1:0] chan(input logic [ATTR_W-1:0] a,
                                                    input logic [1:0] c);
      logic [CHANNEL_BITS-1:0] r;
      case (c)
         2'd0:    r = a[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
         2'd1:    r = a[2*CHANNEL_BITS-1:CHANNEL_BITS];
         default: r = a[CHANNEL_BITS-1:0];
      endcase
      return r;
   endfunction

   // corners (A,B,C) of the chosen triangle
   function automatic logic [5:0] tri_corners(input mode_type m, input logic half);
      logic [5:0] r;
      if (m == MODE_DIAG02) begin
         r = half ? {2'd0, 2'd1, 2'd2} : {2'd2, 2'd3, 2'd0};
      end else begin
         r = half ? {2'd1, 2'd2, 2'd3} : {2'd3, 2'd0, 2'd1};
      end
      return r;
   endfunction

endpackage

/* rtl/qai_req_if.sv */
interface qai_req_if;
   import qai_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] u_coord;
   logic [COORD_W-1:0] v_coord;
   logic               triangle_half;
   modport source (output valid, u_coord, v_coord, triangle_half, input ready);
   modport sink (input valid, u_coord, v_coord, triangle_half, output ready);
endinterface

/* rtl/qai_rsp_if.sv */
interface qai_rsp_if;
   import qai_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red;
   logic [CHANNEL_BITS-1:0] green;
   logic [CHANNEL_BITS-1:0] blue;
   logic                    div_zero;
   modport source (output valid, red, green, blue, div_zero, input ready);
   modport sink (input valid, red, green, blue, div_zero, output ready);
endinterface

/* rtl/qai_csr.sv */
module qai_csr
   import qai_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output cfg_type           cfg
);
   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr  = psel && penable && pwrite;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (idx)
         REG_MODE: begin
            if (wr) cfg_in.mode = mode_type'(pwdata[1:0]);
            prdata = DATA_W'(cfg_ff.mode);
         end
         REG_ATTR0: begin
            if (wr) cfg_in.attr0 = pwdata[ATTR_W-1:0];
            prdata = DATA_W'(cfg_ff.attr0);
         end
         REG_ATTR1: begin
            if (wr) cfg_in.attr1 = pwdata[ATTR_W-1:0];
            prdata = DATA_W'(cfg_ff.attr1);
         end
         REG_ATTR2: begin
            if (wr) cfg_in.attr2 = pwdata[ATTR_W-1:0];
            prdata = DATA_W'(cfg_ff.attr2);
         end
         REG_ATTR3: begin
            if (wr) cfg_in.attr3 = pwdata[ATTR_W-1:0];
            prdata = DATA_W'(cfg_ff.attr3);
         end
         REG_WLOW: begin
            if (wr) cfg_in.w_low = pwdata;
            prdata = cfg_ff.w_low;
         end
         REG_WHIGH: begin
            if (wr) cfg_in.w_high = pwdata;
            prdata = cfg_ff.w_high;
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= MODE_BILIN;
         cfg_ff.attr0  <= ATTR_W'(24'hFF6600);
         cfg_ff.attr1  <= ATTR_W'(24'hE6BF00);
         cfg_ff.attr2  <= ATTR_W'(24'h800080);
         cfg_ff.attr3  <= ATTR_W'(24'h0000FF);
         cfg_ff.w_low  <= 32'h02000200;
         cfg_ff.w_high <= 32'h02000200;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

/* rtl/qai_front.sv */
module qai_front
   import qai_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  cfg_type            cfg,
   input  logic               in_valid,
   input  logic [COORD_W-1:0] u_coord,
   input  logic [COORD_W-1:0] v_coord,
   input  logic               triangle_half,
   output logic               out_valid,
   output item_type           out_item
);
   // stage 1: clamp and corner selection
   logic               s1_valid_ff;
   item_type           s1_ff, s1_in;
   logic [COORD_W-1:0] uc, vc;
   logic [COORD_W:0]   uv;
   logic [5:0]         tc;

   // stage 2: products
   logic               s2_valid_ff;
   item_type           s2_ff;
   logic [PROD_W-1:0]  pa_ff, pb_ff, pc_ff, pa_in, pb_in, pc_in;
   logic [LERP_W-1:0]  lp0_ff [3], lp1_ff [3], lq3_ff [3], lq2_ff [3];
   logic [LERP_W-1:0]  lp0_in [3], lp1_in [3], lq3_in [3], lq2_in [3];

   // stage 3: sums
   logic               s3_valid_ff;
   item_type           s3_ff, s3_in;

   always_comb begin
      uc = (u_coord > ONE_Q) ? ONE_Q : u_coord;
      vc = (v_coord > ONE_Q) ? ONE_Q : v_coord;
      uv = {1'b0, uc} + {1'b0, vc};
      tc = tri_corners(cfg.mode, triangle_half);
      s1_in       = '0;
      s1_in.mode  = cfg.mode;
      s1_in.u     = uc;
      s1_in.v     = vc;
      s1_in.w3    = (uv >= {1'b0, ONE_Q}) ? '0 : COORD_W'({1'b0, ONE_Q} - uv);
      s1_in.ia    = tc[5:4];
      s1_in.ib    = tc[3:2];
      s1_in.ic    = tc[1:0];
   end

   always_comb begin
      pa_in = PROD_W'(corner_weight(cfg, s1_ff.ia)) * PROD_W'(s1_ff.u);
      pb_in = PROD_W'(corner_weight(cfg, s1_ff.ib)) * PROD_W'(s1_ff.v);
      pc_in = PROD_W'(corner_weight(cfg, s1_ff.ic)) * PROD_W'(s1_ff.w3);
      for (int c = 0; c < 3; c++) begin
         lp0_in[c] = LERP_W'(chan(cfg.attr0, 2'(c))) * LERP_W'(ONE_Q - s1_ff.v);
         lp1_in[c] = LERP_W'(chan(cfg.attr1, 2'(c))) * LERP_W'(s1_ff.v);
         lq3_in[c] = LERP_W'(chan(cfg.attr3, 2'(c))) * LERP_W'(ONE_Q - s1_ff.v);
         lq2_in[c] = LERP_W'(chan(cfg.attr2, 2'(c))) * LERP_W'(s1_ff.v);
      end
   end

   always_comb begin
      logic [LERP_W:0] sp, sq;
      s3_in       = s2_ff;
      s3_in.s     = SUM_W'(pa_ff) + SUM_W'(pb_ff) + SUM_W'(pc_ff);
      s3_in.rem_a = REM_W'(pa_ff);
      s3_in.rem_b = REM_W'(pb_ff);
      s3_in.quo_a = '0;
      s3_in.quo_b = '0;
      for (int c = 0; c < 3; c++) begin
         sp = {1'b0, lp0_ff[c]} + {1'b0, lp1_ff[c]};
         sq = {1'b0, lq3_ff[c]} + {1'b0, lq2_ff[c]};
         s3_in.p[(2-c)*CHANNEL_BITS +: CHANNEL_BITS] = sp[FRAC_BITS +: CHANNEL_BITS];
         s3_in.q[(2-c)*CHANNEL_BITS +: CHANNEL_BITS] = sq[FRAC_BITS +: CHANNEL_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= s1_in;
         s2_ff  <= s1_ff;
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         pc_ff  <= pc_in;
         lp0_ff <= lp0_in;
         lp1_ff <= lp1_in;
         lq3_ff <= lq3_in;
         lq2_ff <= lq2_in;
         s3_ff  <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_ff;
endmodule

/* rtl/qai_div_step.sv */
module qai_div_step
   import qai_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     first_step,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     out_valid,
   output item_type out_item
);
   logic     valid_ff;
   item_type item_ff, item_in;

   always_comb begin
      logic [REM_W:0] ta, tb, sx;
      logic           ga, gb;
      // first step tests the top quotient bit without shifting
      ta = first_step ? {1'b0, in_item.rem_a} : {in_item.rem_a, 1'b0};
      tb = first_step ? {1'b0, in_item.rem_b} : {in_item.rem_b, 1'b0};
      sx = (REM_W+1)'(in_item.s);
      ga = ta >= sx;
      gb = tb >= sx;
      item_in       = in_item;
      item_in.rem_a = REM_W'(ga ? ta - sx : ta);
      item_in.rem_b = REM_W'(gb ? tb - sx : tb);
      item_in.quo_a = {in_item.quo_a[COORD_W-2:0], ga};
      item_in.quo_b = {in_item.quo_b[COORD_W-2:0], gb};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

/* rtl/qai_blend.sv */
module qai_blend
   import qai_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   input  item_type                in_item,
   output logic                    out_valid,
   output logic [CHANNEL_BITS-1:0] red,
   output logic [CHANNEL_BITS-1:0] green,
   output logic [CHANNEL_BITS-1:0] blue,
   output logic                    div_zero
);
   logic                    b1_valid_ff, b2_valid_ff;
   logic                    dz_ff, dz_in, dz2_ff;
   logic [LERP_W-1:0]       ma_ff [3], mb_ff [3], mc_ff [3];
   logic [LERP_W-1:0]       ma_in [3], mb_in [3], mc_in [3];
   logic [CHANNEL_BITS-1:0] res_ff [3], res_in [3];

   always_comb begin
      logic [COORD_W-1:0] wa, wb, wc;
      logic [COORD_W:0]   wab;
      logic [ATTR_W-1:0]  ca, cb, cc;
      ca    = corner_attr(cfg, in_item.ia);
      cb    = corner_attr(cfg, in_item.ib);
      cc    = corner_attr(cfg, in_item.ic);
      wa    = in_item.u;
      wb    = in_item.v;
      wc    = in_item.w3;
      dz_in = 1'b0;
      wab   = {1'b0, in_item.quo_a} + {1'b0, in_item.quo_b};
      case (in_item.mode)
         MODE_BILIN: begin
            ca = in_item.p;
            cb = in_item.q;
            cc = '0;
            wa = ONE_Q - in_item.u;
            wb = in_item.u;
            wc = '0;
         end
         MODE_PERSP: begin
            if (in_item.s == '0) begin
               // zero weighted sum: return corner C untouched
               dz_in = 1'b1;
               wa    = '0;
               wb    = '0;
               wc    = ONE_Q;
            end else begin
               wa = in_item.quo_a;
               wb = in_item.quo_b;
               wc = (wab >= {1'b0, ONE_Q}) ? '0 : COORD_W'({1'b0, ONE_Q} - wab);
            end
         end
         default: begin
         end
      endcase
      for (int c = 0; c < 3; c++) begin
         ma_in[c] = LERP_W'(chan(ca, 2'(c))) * LERP_W'(wa);
         mb_in[c] = LERP_W'(chan(cb, 2'(c))) * LERP_W'(wb);
         mc_in[c] = LERP_W'(chan(cc, 2'(c))) * LERP_W'(wc);
      end
   end

   always_comb begin
      logic [ACC_W-1:0] acc;
      for (int c = 0; c < 3; c++) begin
         acc = ACC_W'(ma_ff[c]) + ACC_W'(mb_ff[c]) + ACC_W'(mc_ff[c]);
         // saturate where the clamped third weight lets a channel overflow
         if (acc[ACC_W-1:FRAC_BITS] > (ACC_W-FRAC_BITS)'({CHANNEL_BITS{1'b1}})) begin
            res_in[c] = '1;
         end else begin
            res_in[c] = acc[FRAC_BITS +: CHANNEL_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
      end else if (en) begin
         b1_valid_ff <= in_valid;
         b2_valid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff  <= ma_in;
         mb_ff  <= mb_in;
         mc_ff  <= mc_in;
         dz_ff  <= dz_in;
         res_ff <= res_in;
         dz2_ff <= dz_ff;
      end
   end

   assign out_valid = b2_valid_ff;
   assign red       = res_ff[0];
   assign green     = res_ff[1];
   assign blue      = res_ff[2];
   assign div_zero  = dz2_ff;
endmodule

/* rtl/quad_attribute_interpolator.sv */
// Quad attribute interpolator.
// Items arrive on req_chan (u_coord, v_coord, triangle_half) and leave on
// rsp_chan (red, green, blue, div_zero), both valid/ready; an item moves
// when valid and ready are high at a clock edge. One result per item, in order.
// Corner colours, perspective weights and mode sit in an APB register file
// (psel/penable/pwrite/paddr/pwdata/prdata/pready, pready always high).
// Write registers only while no item is in flight.
// 22 register stages: three front stages (clamp/select, products, sums),
// seventeen restoring divider steps, one quotient bit each for both
// normalised weights, then two blend stages.
// Throughput: one item per cycle while the receiver keeps up; every mode takes the same path.
// When the receiver stalls the whole pipeline holds and req ready drops only
// while the output stage holds an untaken result.
// Reset (synchronous, active high) empties the pipeline and restores the
// register defaults: bilinear mode, the default corner colours and all
// perspective weights at 2.0.
module quad_attribute_interpolator
   import qai_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   qai_req_if.sink           req_chan,
   qai_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);
   cfg_type  cfg;
   logic     en;
   logic     dv [DIV_STEPS+1];
   item_type di [DIV_STEPS+1];

   // advance unless a finished item waits at the output
   assign en             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;
   assign pready         = 1'b1;

   qai_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   qai_front u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .cfg           (cfg),
      .in_valid      (req_chan.valid),
      .u_coord       (req_chan.u_coord),
      .v_coord       (req_chan.v_coord),
      .triangle_half (req_chan.triangle_half),
      .out_valid     (dv[0]),
      .out_item      (di[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      qai_div_step u_step (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .first_step (i == 0),
         .in_valid   (dv[i]),
         .in_item    (di[i]),
         .out_valid  (dv[i+1]),
         .out_item   (di[i+1])
      );
   end

   qai_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg),
      .in_valid  (dv[DIV_STEPS]),
      .in_item   (di[DIV_STEPS]),
      .out_valid (rsp_chan.valid),
      .red       (rsp_chan.red),
      .green     (rsp_chan.green),
      .blue      (rsp_chan.blue),
      .div_zero  (rsp_chan.div_zero)
   );
endmodule
